>>> hdl/nrg_pkg.sv
`default_nettype none
package nrg_pkg;

    localparam int OUT_W = 13;
    localparam int QIDX_W = 12;
    localparam int VAL_IN_W = 32;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // -1 as a 13-bit two's complement result
    localparam logic [OUT_W-1:0] PREV_NONE = {OUT_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_cmd;

    typedef struct packed {
        logic prev_we;
        logic next_we;
        logic rd_en;
    } t_tbl_cmd;

endpackage
`default_nettype wire

>>> hdl/nrg_stack.sv
`default_nettype none
module nrg_stack
    import nrg_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int EW = 77
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_stk_cmd      i_cmd,
    input  wire logic [EW-1:0] i_entry,
    output logic      [EW-1:0] o_top,
    output logic               o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // top entry lives in r_top, the memory holds the entries below it
    logic [EW-1:0] mem [DEPTH];

    logic [CW-1:0] r_depth, n_depth;
    logic [EW-1:0] r_top;
    logic [EW-1:0] r_rd;
    logic [EW-1:0] r_fwd_data;
    logic          r_fwd_hit;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] below;

    always_comb begin
        priority if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = CW'(r_depth + 1'b1);
        end else if (i_cmd.pop) begin
            n_depth = CW'(r_depth - 1'b1);
        end else begin
            n_depth = r_depth;
        end
    end

    assign wr_en   = i_cmd.push && (r_depth != '0);
    assign wr_addr = AW'(r_depth - 1'b1);
    // keep the entry just below the top read out for the next depth
    assign rd_addr = AW'(n_depth - CW'(2));
    assign below   = r_fwd_hit ? r_fwd_data : r_rd;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_top;
        end
        r_rd       <= mem[rd_addr];
        r_fwd_data <= r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_fwd_hit <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_entry;
        end else if (i_cmd.pop) begin
            r_top <= below;
        end
    end

    assign o_top   = r_top;
    assign o_empty = (r_depth == '0);

endmodule
`default_nettype wire

>>> hdl/nrg_tables.sv
`default_nettype none
module nrg_tables
    import nrg_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire t_tbl_cmd                 i_cmd,
    input  wire logic [$clog2(DEPTH)-1:0] i_prev_addr,
    input  wire logic [$clog2(DEPTH):0]   i_prev_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_next_addr,
    input  wire logic [$clog2(DEPTH)-1:0] i_next_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [$clog2(DEPTH):0]   o_prev,
    output logic      [$clog2(DEPTH)-1:0] o_next
);

    localparam int AW = $clog2(DEPTH);

    // prev entry: {no greater earlier, index}; next entry of zero means none yet
    logic [AW:0]   prev_mem [DEPTH];
    logic [AW-1:0] next_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.prev_we) begin
            prev_mem[i_prev_addr] <= i_prev_data;
        end
        if (i_cmd.next_we) begin
            next_mem[i_next_addr] <= i_next_data;
        end
        if (i_cmd.rd_en) begin
            o_prev <= prev_mem[i_rd_addr];
            o_next <= next_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/nearest_greater_values_top.sv
// Nearest greater values: append items fill an array from index 0, a clear
// item empties it, and a query returns the nearest earlier and later indexes
// holding a strictly greater value. A transaction is taken when start is high
// and busy is low. A clear, a dropped append (array full) and an unused kind
// finish in the accept cycle. An append is accepted, then pops each smaller
// entry off the monotonic stack in turn, one per step, and then pushes its own
// entry (at most one pop per append on average). A query reads the table
// memories in its accept cycle, and o_valid pulses for exactly one cycle in
// the cycle after it. The receiver cannot stall, so the result must be taken
// on that cycle. After reset the block is ready at once.
`default_nettype none
module nearest_greater_values_top
    import nrg_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [VAL_IN_W-1:0] i_value,
    input  wire logic [QIDX_W-1:0]   i_query_index,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_prev_greater,
    output logic [OUT_W-1:0]         o_next_greater,
    output logic                     o_bad_index
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VB = VALUE_BITS;
    localparam int EW = 2 * AW + VB + 1;
    localparam int QW = (CW > QIDX_W) ? CW : QIDX_W;
    localparam int WW = (CW > OUT_W) ? CW : OUT_W;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [VB-1:0] r_val;
    logic          r_bad;

    t_stk_cmd      stk_cmd;
    logic [EW-1:0] stk_entry;
    logic [EW-1:0] stk_top;
    logic          stk_empty;

    t_tbl_cmd      tbl_cmd;
    logic [AW-1:0] prev_addr;
    logic [AW:0]   prev_data;
    logic [AW-1:0] next_addr;
    logic [AW-1:0] next_data;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   tbl_prev;
    logic [AW-1:0] tbl_next;

    logic [AW-1:0] top_idx;
    logic [VB-1:0] top_val;
    logic [AW:0]   top_prev;
    logic [AW-1:0] cur_idx;
    logic          top_less;
    logic [QW-1:0] q_ext;
    logic          q_bad;
    logic          accept;

    logic [WW-1:0] prev_wide;
    logic [WW-1:0] next_wide;

    assign top_idx  = stk_top[EW-1 -: AW];
    assign top_val  = stk_top[AW+VB:AW+1];
    assign top_prev = stk_top[AW:0];
    assign cur_idx  = r_count[AW-1:0];
    assign top_less = !stk_empty && (top_val < r_val);
    assign q_ext    = QW'(i_query_index);
    assign q_bad    = q_ext >= QW'(r_count);
    assign accept   = start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        stk_cmd   = '0;
        tbl_cmd   = '0;
        prev_addr = cur_idx;
        next_addr = cur_idx;
        next_data = '0;
        rd_addr   = AW'(q_ext);
        prev_data = {1'b0, top_idx};
        busy      = 1'b1;
        o_valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    unique case (i_kind)
                        KIND_CLEAR: begin
                            stk_cmd.clear = 1'b1;
                            n_count       = '0;
                        end
                        KIND_APPEND: begin
                            // full array drops the value
                            if (r_count != CW'(DEPTH)) begin
                                n_state = S_APPEND;
                            end
                        end
                        KIND_QUERY: begin
                            tbl_cmd.rd_en = 1'b1;
                            n_state       = S_RESULT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (top_less) begin
                    // smaller top finds its next greater here
                    stk_cmd.pop     = 1'b1;
                    tbl_cmd.next_we = 1'b1;
                    next_addr       = top_idx;
                    next_data       = cur_idx;
                end else begin
                    priority if (stk_empty) begin
                        prev_data = {1'b1, {AW{1'b0}}};
                    end else if (top_val > r_val) begin
                        prev_data = {1'b0, top_idx};
                    end else begin
                        // equal top: share its answer
                        prev_data = top_prev;
                    end
                    tbl_cmd.prev_we = 1'b1;
                    tbl_cmd.next_we = 1'b1;
                    stk_cmd.push    = 1'b1;
                    n_count         = CW'(r_count + 1'b1);
                    n_state         = S_IDLE;
                end
            end
            S_RESULT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        stk_entry = {cur_idx, r_val, prev_data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= VB'(i_value);
            r_bad <= q_bad;
        end
    end

    nrg_stack #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .i_entry (stk_entry),
        .o_top   (stk_top),
        .o_empty (stk_empty)
    );

    nrg_tables #(
        .DEPTH (DEPTH)
    ) u_tables (
        .i_clk       (i_clk),
        .i_cmd       (tbl_cmd),
        .i_prev_addr (prev_addr),
        .i_prev_data (prev_data),
        .i_next_addr (next_addr),
        .i_next_data (next_data),
        .i_rd_addr   (rd_addr),
        .o_prev      (tbl_prev),
        .o_next      (tbl_next)
    );

    assign prev_wide = WW'(tbl_prev[AW-1:0]);
    assign next_wide = (r_bad || (tbl_next == '0)) ? WW'(r_count) : WW'(tbl_next);

    assign o_prev_greater = (r_bad || tbl_prev[AW]) ? PREV_NONE : prev_wide[OUT_W-1:0];
    assign o_next_greater = next_wide[OUT_W-1:0];
    assign o_bad_index    = r_bad;

endmodule
`default_nettype wire

>>> tb/nearest_greater_values_checker.sv
`timescale 1ns / 1ps
module nearest_greater_values_checker
    import nrg_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [VAL_IN_W-1:0] i_value,
    input  wire logic [QIDX_W-1:0]   i_query_index,
    input  wire logic                o_valid,
    input  wire logic [OUT_W-1:0]    o_prev_greater,
    input  wire logic [OUT_W-1:0]    o_next_greater,
    input  wire logic                o_bad_index,
    output int                       fail_count,
    output int                       pending,
    output int                       answers_checked
);

    typedef struct packed {
        logic [OUT_W-1:0] prev_greater;
        logic [OUT_W-1:0] next_greater;
        logic             bad_index;
    } t_neighbors;

    localparam logic [63:0] VALUE_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

    // shadow of the array and its monotonic stack
    logic [63:0]       values     [DEPTH];
    logic [QIDX_W-1:0] mono_stack [DEPTH];
    logic [OUT_W-1:0]  prev_index [DEPTH];
    logic [OUT_W-1:0]  next_index [DEPTH];
    int                entry_count;
    int                stack_depth;
    t_neighbors        answers_due [$];

    task automatic append_value(input logic [VAL_IN_W-1:0] raw);
        logic [63:0]       v;
        logic [QIDX_W-1:0] top;
        int                n;
        n = entry_count;
        if (n >= DEPTH) return;
        v = {32'd0, raw} & VALUE_MASK;
        values[n] = v;
        next_index[n] = '0;
        while (stack_depth > 0 && values[mono_stack[stack_depth-1]] < v) begin
            next_index[mono_stack[stack_depth-1]] = OUT_W'(n);
            stack_depth--;
        end
        if (stack_depth == 0) begin
            prev_index[n] = PREV_NONE;
        end else begin
            top = mono_stack[stack_depth-1];
            // everything between top and n is smaller than v
            prev_index[n] = (values[top] > v) ? OUT_W'(top) : prev_index[top];
        end
        if (stack_depth < DEPTH) begin
            mono_stack[stack_depth] = QIDX_W'(n);
            stack_depth++;
        end
        entry_count = n + 1;
    endtask

    function automatic t_neighbors lookup_neighbors(input logic [QIDX_W-1:0] q);
        t_neighbors a;
        if (int'(q) >= entry_count) begin
            a.prev_greater = PREV_NONE;
            a.next_greater = OUT_W'(entry_count);
            a.bad_index    = 1'b1;
        end else begin
            a.prev_greater = prev_index[q];
            a.next_greater = (next_index[q] == '0) ? OUT_W'(entry_count) : next_index[q];
            a.bad_index    = 1'b0;
        end
        return a;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_neighbors e;
        if (!i_rst_n) begin
            entry_count = 0;
            stack_depth = 0;
            answers_due.delete();
        end else begin
            // compare before predicting: a result never belongs to this edge's transaction
            if (o_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result with no query outstanding: prev %0d next %0d bad %0b",
                           $signed(o_prev_greater), o_next_greater, o_bad_index);
                    fail_count++;
                end else begin
                    e = answers_due.pop_front();
                    answers_checked++;
                    if (o_prev_greater !== e.prev_greater) begin
                        $error("prev_greater: expected %0d, actual %0d",
                               $signed(e.prev_greater), $signed(o_prev_greater));
                        fail_count++;
                    end
                    if (o_next_greater !== e.next_greater) begin
                        $error("next_greater: expected %0d, actual %0d",
                               e.next_greater, o_next_greater);
                        fail_count++;
                    end
                    if (o_bad_index !== e.bad_index) begin
                        $error("bad_index: expected %0b, actual %0b", e.bad_index, o_bad_index);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                case (i_kind)
                    KIND_CLEAR: begin
                        entry_count = 0;
                        stack_depth = 0;
                    end
                    KIND_APPEND: append_value(i_value);
                    KIND_QUERY:  answers_due.push_back(lookup_neighbors(i_query_index));
                    default: ;
                endcase
            end
        end
        pending = answers_due.size();
    end

endmodule

>>> tb/nearest_greater_values_top_tb.sv
`timescale 1ns / 1ps
module nearest_greater_values_top_tb;
    import nrg_pkg::*;

    localparam int DEPTH = 4096;
    localparam int VALUE_BITS = 32;
    localparam int RANDOM_ITEMS = 1050;
    localparam int FILL_LEN = 300;
    // longest legal quiet stretch is a full-depth stack unwind
    localparam int STALL_LIMIT = 20000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [KIND_W-1:0]       i_kind;
    logic [VAL_IN_W-1:0]     i_value;
    logic [QIDX_W-1:0]       i_query_index;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_prev_greater;
    logic [OUT_W-1:0]        o_next_greater;
    logic                    o_bad_index;

    int fail_count;
    int pending;
    int answers_checked;

    int shadow_count;
    int n_append;
    int n_query;
    int n_clear;
    int n_unused;
    int quiet_cycles;

    nearest_greater_values_top #(
        .DEPTH(DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_value(i_value),
        .i_query_index(i_query_index),
        .o_valid(o_valid),
        .o_prev_greater(o_prev_greater),
        .o_next_greater(o_next_greater),
        .o_bad_index(o_bad_index)
    );

    nearest_greater_values_checker #(
        .DEPTH(DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_value(i_value),
        .i_query_index(i_query_index),
        .o_valid(o_valid),
        .o_prev_greater(o_prev_greater),
        .o_next_greater(o_next_greater),
        .o_bad_index(o_bad_index),
        .fail_count(fail_count),
        .pending(pending),
        .answers_checked(answers_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d answers outstanding",
                     STALL_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(input logic [KIND_W-1:0] k, input logic [VAL_IN_W-1:0] v,
                        input logic [QIDX_W-1:0] q);
        start <= 1'b1;
        i_kind <= k;
        i_value <= v;
        i_query_index <= q;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        case (k)
            KIND_CLEAR: begin
                shadow_count = 0;
                n_clear++;
            end
            KIND_APPEND: begin
                if (shadow_count < DEPTH) shadow_count++;
                n_append++;
            end
            KIND_QUERY: n_query++;
            default: n_unused++;
        endcase
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [QIDX_W-1:0] pick_index();
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            return QIDX_W'($urandom_range(0, shadow_count - 1));
        return QIDX_W'($urandom);
    endfunction

    function automatic logic [VAL_IN_W-1:0] pick_value(input int mode, input int pos);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 6) return '1;
        case (mode)
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 255);
            2: return $urandom;
            3: return 32'hFFFF_0000 - pos * 3 + $urandom_range(0, 4);
            default: return 32'h0000_1000 + pos * 3 - $urandom_range(0, 4);
        endcase
    endfunction

    initial begin
        int seq_len;
        int appended;
        int mode;
        int random_items;
        bit no_idle;
        start = 1'b0;
        i_kind = KIND_CLEAR;
        i_value = '0;
        i_query_index = '0;
        i_rst_n = 1'b0;
        shadow_count = 0;
        n_append = 0;
        n_query = 0;
        n_clear = 0;
        n_unused = 0;
        random_items = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty array, extremes, equal values, unused kind, clear
        send(KIND_QUERY, '0, '0);
        send(KIND_QUERY, '0, '1);
        send(KIND_APPEND, '0, '0);
        send(KIND_APPEND, '1, '0);
        send(KIND_APPEND, 32'd5, '0);
        send(KIND_APPEND, 32'd5, '0);
        send(KIND_APPEND, 32'd3, '0);
        send(KIND_APPEND, 32'd7, '0);
        for (int i = 0; i < 7; i++) send(KIND_QUERY, '1, QIDX_W'(i));
        send(KIND_QUERY, '0, '1);
        send(KIND_UNUSED, '1, '1);
        send(KIND_QUERY, '0, 12'd2);
        send(KIND_CLEAR, '1, '1);
        send(KIND_QUERY, '0, '0);

        // drain completely before the long descending run
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        // long descending run, then one huge value unwinds the whole stack
        for (int i = 0; i < FILL_LEN - 1; i++) send(KIND_APPEND, 32'd100000 - i, '0);
        send(KIND_APPEND, '1, '0);
        send(KIND_APPEND, '1, '0);
        send(KIND_QUERY, '0, '0);
        send(KIND_QUERY, '0, '1);
        send(KIND_QUERY, '0, QIDX_W'(FILL_LEN - 2));
        send(KIND_QUERY, '0, QIDX_W'(FILL_LEN / 2));
        for (int i = 0; i < 20; i++) begin
            hold_off(gap_length());
            send(KIND_QUERY, $urandom, pick_index());
        end
        send(KIND_CLEAR, '0, '0);

        while (random_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: unused kind or a stray query
                hold_off(gap_length());
                if ($urandom_range(0, 1)) begin
                    send(KIND_UNUSED, $urandom, QIDX_W'($urandom));
                end else begin
                    send(KIND_QUERY, $urandom, QIDX_W'($urandom));
                    random_items++;
                end
                continue;
            end
            if ($urandom_range(0, 9) < 7) begin
                hold_off(no_idle ? 0 : gap_length());
                send(KIND_CLEAR, $urandom, QIDX_W'($urandom));
                random_items++;
            end
            seq_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
            mode = $urandom_range(0, 4);
            appended = 0;
            while (appended < seq_len) begin
                hold_off(no_idle ? 0 : gap_length());
                if ($urandom_range(0, 99) < 35) begin
                    send(KIND_QUERY, $urandom, pick_index());
                end else begin
                    send(KIND_APPEND, pick_value(mode, appended), QIDX_W'($urandom));
                    appended++;
                end
                random_items++;
            end
            repeat ($urandom_range(2, 10)) begin
                hold_off(no_idle ? 0 : gap_length());
                send(KIND_QUERY, $urandom, pick_index());
                random_items++;
            end
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("checked %0d query answers; %0d appends, %0d clears, %0d unused-kind items",
                 answers_checked, n_append, n_clear, n_unused);
        $display("covered a long descending run with full stack unwind, "
                 , "equal and extreme values, out-of-range queries");
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> nearest_greater_values_top.f
hdl/nrg_pkg.sv
hdl/nrg_stack.sv
hdl/nrg_tables.sv
hdl/nearest_greater_values_top.sv
tb/nearest_greater_values_checker.sv
tb/nearest_greater_values_top_tb.sv
